/* hw/rtl/kronecker_edge_builder_assert.svh */
// Assertion macros for the Kronecker edge builder.
// Used by the top level only; needs a clock and an active-low reset in scope at the call.
`ifndef KRONECKER_EDGE_BUILDER_ASSERT_SVH
`define KRONECKER_EDGE_BUILDER_ASSERT_SVH

// Same-cycle implication, switched off while reset is held
`define KEB_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("kronecker_edge_builder: same-cycle check failed");

// Next-cycle implication, switched off while reset is held
`define KEB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("kronecker_edge_builder: next-cycle check failed");

`endif

/* hw/rtl/keb_pkg.sv */
// Shared constants, types and command codes for the Kronecker edge builder.
// No dependencies; the other RTL files but the assertion header refer to it by scoped names.
`default_nettype none

package keb_pkg;

  // Sizes
  localparam int unsigned MAX_LOG_VERTICES = 48;
  localparam int unsigned PFX_W            = MAX_LOG_VERTICES;
  localparam int unsigned WORD_W           = 31;
  localparam int unsigned LV_W             = 6;
  localparam int unsigned KEY_W            = 64;
  localparam int unsigned HALF_W           = KEY_W / 2;
  localparam int unsigned SH_W             = 7;
  localparam int unsigned A_W              = 14;
  localparam int unsigned BC_W             = 13;
  localparam int unsigned OUT_W            = 48;
  localparam int unsigned CFG_IDX_W        = 3;
  localparam int unsigned CFG_DATA_W       = 64;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LOG_VERTICES = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_FIRST    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_SECOND   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_A_SHARE      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BC_SHARE     = 3'd4;

  // Register reset values
  localparam logic [LV_W-1:0]  RST_LOG_VERTICES = 6'd16;
  localparam logic [KEY_W-1:0] RST_KEY_FIRST    = 64'd0;
  localparam logic [KEY_W-1:0] RST_KEY_SECOND   = 64'd1;
  localparam logic [A_W-1:0]   RST_A_SHARE      = 14'd5700;
  localparam logic [BC_W-1:0]  RST_BC_SHARE     = 13'd1900;

  // Word reduction: reject below 2^31-1 mod 10000, then reduce mod 10000
  localparam logic [WORD_W-1:0] REJECT_LIMIT = 31'd3647;
  localparam int unsigned       DENOM_W      = 14;
  localparam logic [DENOM_W-1:0] SHARE_DENOM = 14'd10000;
  // floor(2^44 / 10000); the estimated quotient is exact or one short
  localparam int unsigned       RECIP_SHIFT  = 44;
  localparam logic [WORD_W-1:0] RECIP        = 31'd1759218604;
  localparam int unsigned       RECIP_PROD_W = 2 * WORD_W;
  localparam int unsigned       QUOT_W       = RECIP_PROD_W - RECIP_SHIFT;
  localparam int unsigned       QMUL_W       = QUOT_W + DENOM_W;

  // Scramble multiplier constants
  localparam logic [KEY_W-1:0] MUL_FIRST  = 64'h4519840211493211;
  localparam logic [KEY_W-1:0] MUL_SECOND = 64'h3050852102C843A5;

  // Scramble register operations
  localparam logic [1:0] X_HOLD    = 2'd0;
  localparam logic [1:0] X_ADD_SRC = 2'd1;
  localparam logic [1:0] X_ADD_TGT = 2'd2;
  localparam logic [1:0] X_MIX     = 2'd3;

  // Partial product selection
  localparam logic [1:0] MUL_LL = 2'd0;
  localparam logic [1:0] MUL_LH = 2'd1;
  localparam logic [1:0] MUL_HL = 2'd2;

  // Accumulator operations
  localparam logic [1:0] ACC_HOLD = 2'd0;
  localparam logic [1:0] ACC_LOAD = 2'd1;
  localparam logic [1:0] ACC_ADD  = 2'd2;

  typedef struct packed {
    logic [LV_W-1:0]  log_vertices;
    logic [KEY_W-1:0] key_first;
    logic [KEY_W-1:0] key_second;
    logic [A_W-1:0]   a_share;
    logic [BC_W-1:0]  bc_share;
  } cfg_t;

  // Controller to datapath
  typedef struct packed {
    logic       take_word;
    logic       qmul_load;
    logic       level_step;
    logic [1:0] x_op;
    logic [1:0] mul_sel;
    logic       use_second_key;
    logic [1:0] acc_op;
    logic       hold_src;
    logic       out_load;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic word_ok;
    logic edge_done;
    logic out_busy;
  } status_t;

endpackage

`default_nettype wire

/* hw/rtl/keb_if.sv */
// Channel interfaces: random words in, scrambled edges out.
// Depends on keb_pkg for field widths.
`default_nettype none

interface keb_word_if;
  logic                         valid;
  logic                         ready;
  logic [keb_pkg::WORD_W-1:0]   random_word;

  modport source (output valid, output random_word, input ready);
  modport sink   (input valid, input random_word, output ready);
endinterface

interface keb_edge_if;
  logic                        valid;
  logic                        ready;
  logic [keb_pkg::OUT_W-1:0]   source_vertex;
  logic [keb_pkg::OUT_W-1:0]   target_vertex;

  modport source (output valid, output source_vertex, output target_vertex, input ready);
  modport sink   (input valid, input source_vertex, input target_vertex, output ready);
endinterface

`default_nettype wire

/* hw/rtl/keb_cfg.sv */
// Configuration register file of the Kronecker edge builder.
// Depends on keb_pkg for register indexes, widths and reset values.
`default_nettype none

module keb_cfg (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               we,
  input  logic [keb_pkg::CFG_IDX_W-1:0]      index,
  input  logic [keb_pkg::CFG_DATA_W-1:0]     wdata,
  output keb_pkg::cfg_t                      cfg
);

  keb_pkg::cfg_t cfg_r, cfg_nxt;

  // Register decode; unknown indexes are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (we) begin
      unique case (index)
        keb_pkg::CFG_LOG_VERTICES: cfg_nxt.log_vertices = wdata[keb_pkg::LV_W-1:0];
        keb_pkg::CFG_KEY_FIRST:    cfg_nxt.key_first    = wdata[keb_pkg::KEY_W-1:0];
        keb_pkg::CFG_KEY_SECOND:   cfg_nxt.key_second   = wdata[keb_pkg::KEY_W-1:0];
        keb_pkg::CFG_A_SHARE:      cfg_nxt.a_share      = wdata[keb_pkg::A_W-1:0];
        keb_pkg::CFG_BC_SHARE:     cfg_nxt.bc_share     = wdata[keb_pkg::BC_W-1:0];
        default:                   cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.log_vertices <= keb_pkg::RST_LOG_VERTICES;
      cfg_r.key_first    <= keb_pkg::RST_KEY_FIRST;
      cfg_r.key_second   <= keb_pkg::RST_KEY_SECOND;
      cfg_r.a_share      <= keb_pkg::RST_A_SHARE;
      cfg_r.bc_share     <= keb_pkg::RST_BC_SHARE;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

/* hw/rtl/keb_ctrl.sv */
// Sequencing controller: word reduction steps, then the two-vertex scramble.
// Depends on keb_pkg for command and status types and operation codes.
`default_nettype none

module keb_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  keb_pkg::status_t  status,
  output logic              in_ready,
  output keb_pkg::cmd_t     cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_QMUL  = 4'd1;
  localparam logic [3:0] S_LEVEL = 4'd2;
  localparam logic [3:0] S_ADD   = 4'd3;
  localparam logic [3:0] S_M0    = 4'd4;
  localparam logic [3:0] S_M1    = 4'd5;
  localparam logic [3:0] S_M2    = 4'd6;
  localparam logic [3:0] S_M3    = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;

  logic [3:0] state_r, state_nxt;
  logic       vsel_r, vsel_nxt;   // 0: source vertex, 1: target vertex
  logic       pass_r, pass_nxt;   // 0: first multiply, 1: second multiply

  assign in_ready = (state_r == S_IDLE);

  // Next state and command decode
  always_comb begin
    state_nxt          = state_r;
    vsel_nxt           = vsel_r;
    pass_nxt           = pass_r;
    cmd                = '0;
    cmd.x_op           = keb_pkg::X_HOLD;
    cmd.mul_sel        = keb_pkg::MUL_LL;
    cmd.acc_op         = keb_pkg::ACC_HOLD;
    cmd.use_second_key = pass_r;
    unique case (state_r)
      S_IDLE: begin
        // a rejected word is taken and dropped
        if (in_valid && status.word_ok) begin
          cmd.take_word = 1'b1;
          state_nxt     = S_QMUL;
        end
      end
      S_QMUL: begin
        cmd.qmul_load = 1'b1;
        state_nxt     = S_LEVEL;
      end
      S_LEVEL: begin
        cmd.level_step = 1'b1;
        if (status.edge_done) begin
          vsel_nxt  = 1'b0;
          state_nxt = S_ADD;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_ADD: begin
        cmd.x_op     = vsel_r ? keb_pkg::X_ADD_TGT : keb_pkg::X_ADD_SRC;
        cmd.hold_src = vsel_r;
        pass_nxt     = 1'b0;
        state_nxt    = S_M0;
      end
      S_M0: begin
        cmd.mul_sel = keb_pkg::MUL_LL;
        state_nxt   = S_M1;
      end
      S_M1: begin
        cmd.acc_op  = keb_pkg::ACC_LOAD;
        cmd.mul_sel = keb_pkg::MUL_LH;
        state_nxt   = S_M2;
      end
      S_M2: begin
        cmd.acc_op  = keb_pkg::ACC_ADD;
        cmd.mul_sel = keb_pkg::MUL_HL;
        state_nxt   = S_M3;
      end
      S_M3: begin
        cmd.x_op = keb_pkg::X_MIX;
        if (!pass_r) begin
          pass_nxt  = 1'b1;
          state_nxt = S_M0;
        end else if (!vsel_r) begin
          vsel_nxt  = 1'b1;
          state_nxt = S_ADD;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!status.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      vsel_r  <= 1'b0;
      pass_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      vsel_r  <= vsel_nxt;
      pass_r  <= pass_nxt;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/keb_dp.sv */
// Datapath: mod-10000 reduction, quadrant pick, prefix registers, shared
// 32x32 multiplier for the 64-bit scramble, output register. Depends on keb_pkg.
`default_nettype none

module keb_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  keb_pkg::cfg_t                 cfg,
  input  keb_pkg::cmd_t                 cmd,
  input  logic [keb_pkg::WORD_W-1:0]    word_in,
  input  logic                          out_ready,
  output keb_pkg::status_t              status,
  output logic                          out_valid,
  output logic [keb_pkg::OUT_W-1:0]     out_source,
  output logic [keb_pkg::OUT_W-1:0]     out_target
);

  localparam int unsigned DIFF_W = keb_pkg::DENOM_W + 1;

  // Reduction registers
  logic [keb_pkg::WORD_W-1:0]       word_r;
  logic [keb_pkg::RECIP_PROD_W-1:0] recip_r;
  logic [keb_pkg::QMUL_W-1:0]       qmul_r;

  // Level state
  logic [keb_pkg::PFX_W-1:0] src_prefix_r, tgt_prefix_r;
  logic [keb_pkg::LV_W-1:0]  levels_r;

  // Scramble registers
  logic [keb_pkg::PFX_W-1:0] edge_src_r, edge_tgt_r;
  logic [keb_pkg::KEY_W-1:0] x_r, prod_r, acc_r;
  logic [keb_pkg::OUT_W-1:0] res_src_r;

  // Output register
  logic                      out_valid_r;
  logic [keb_pkg::OUT_W-1:0] out_source_r, out_target_r;

  function automatic logic [keb_pkg::KEY_W-1:0] rev64(input logic [keb_pkg::KEY_W-1:0] v);
    logic [keb_pkg::KEY_W-1:0] r;
    for (int i = 0; i < int'(keb_pkg::KEY_W); i++) begin
      r[i] = v[keb_pkg::KEY_W-1-i];
    end
    return r;
  endfunction

  // Level count saturated to 1..MAX_LOG_VERTICES
  logic [keb_pkg::LV_W-1:0] lvl_eff;
  logic [keb_pkg::SH_W-1:0] shift_amt;

  always_comb begin
    if (cfg.log_vertices == '0) begin
      lvl_eff = keb_pkg::LV_W'(1);
    end else if (cfg.log_vertices > keb_pkg::LV_W'(keb_pkg::MAX_LOG_VERTICES)) begin
      lvl_eff = keb_pkg::LV_W'(keb_pkg::MAX_LOG_VERTICES);
    end else begin
      lvl_eff = cfg.log_vertices;
    end
  end

  assign shift_amt = keb_pkg::SH_W'(keb_pkg::KEY_W) - {1'b0, lvl_eff};

  // Quotient estimate by reciprocal, then one correction step
  logic [keb_pkg::RECIP_PROD_W-1:0] recip_prod;
  logic [keb_pkg::QUOT_W-1:0]       quot_est;
  logic [keb_pkg::QMUL_W-1:0]       qmul_prod;
  logic [keb_pkg::WORD_W-1:0]       diff_full;
  logic [DIFF_W-1:0]                diff;
  logic [DIFF_W-1:0]                diff_fix;
  logic [keb_pkg::DENOM_W-1:0]      rem;

  assign recip_prod = {{keb_pkg::WORD_W{1'b0}}, word_in}
                    * {{keb_pkg::WORD_W{1'b0}}, keb_pkg::RECIP};
  assign quot_est   = recip_r[keb_pkg::RECIP_PROD_W-1:keb_pkg::RECIP_SHIFT];
  assign qmul_prod  = {{keb_pkg::DENOM_W{1'b0}}, quot_est}
                    * {{keb_pkg::QUOT_W{1'b0}}, keb_pkg::SHARE_DENOM};
  assign diff_full  = word_r - qmul_r[keb_pkg::WORD_W-1:0];
  assign diff       = diff_full[DIFF_W-1:0];
  assign diff_fix   = (diff >= {1'b0, keb_pkg::SHARE_DENOM})
                    ? diff - {1'b0, keb_pkg::SHARE_DENOM} : diff;
  assign rem        = diff_fix[keb_pkg::DENOM_W-1:0];

  // Quadrant pick with clip-and-flip
  logic [keb_pkg::DENOM_W-1:0] bc_twice;
  logic [keb_pkg::DENOM_W:0]   bc_twice_a;
  logic                        sbit, tbit;

  assign bc_twice   = {cfg.bc_share, 1'b0};
  assign bc_twice_a = {1'b0, bc_twice} + {1'b0, cfg.a_share};

  always_comb begin
    if (rem < {1'b0, cfg.bc_share}) begin
      sbit = 1'b0;
      tbit = 1'b1;
    end else if (rem < bc_twice) begin
      // off-diagonal quadrant folds onto the other while prefixes agree
      sbit = (src_prefix_r != tgt_prefix_r);
      tbit = (src_prefix_r == tgt_prefix_r);
    end else if ({1'b0, rem} < bc_twice_a) begin
      sbit = 1'b0;
      tbit = 1'b0;
    end else begin
      sbit = 1'b1;
      tbit = 1'b1;
    end
  end

  logic [keb_pkg::PFX_W-1:0] src_next, tgt_next;
  logic [keb_pkg::LV_W:0]    lvl_inc;

  assign src_next = {src_prefix_r[keb_pkg::PFX_W-2:0], sbit};
  assign tgt_next = {tgt_prefix_r[keb_pkg::PFX_W-2:0], tbit};
  assign lvl_inc  = {1'b0, levels_r} + (keb_pkg::LV_W+1)'(1);

  // Shared partial-product multiplier
  logic [keb_pkg::KEY_W-1:0]  mul_key;
  logic [keb_pkg::HALF_W-1:0] mul_a, mul_b;
  logic [keb_pkg::KEY_W-1:0]  mix_sum;

  assign mul_key = cmd.use_second_key ? (cfg.key_second | keb_pkg::MUL_SECOND)
                                      : (cfg.key_first  | keb_pkg::MUL_FIRST);

  always_comb begin
    unique case (cmd.mul_sel)
      keb_pkg::MUL_LH: begin
        mul_a = x_r[keb_pkg::HALF_W-1:0];
        mul_b = mul_key[keb_pkg::KEY_W-1:keb_pkg::HALF_W];
      end
      keb_pkg::MUL_HL: begin
        mul_a = x_r[keb_pkg::KEY_W-1:keb_pkg::HALF_W];
        mul_b = mul_key[keb_pkg::HALF_W-1:0];
      end
      default: begin
        mul_a = x_r[keb_pkg::HALF_W-1:0];
        mul_b = mul_key[keb_pkg::HALF_W-1:0];
      end
    endcase
  end

  // cross terms only reach the upper half modulo 2^64
  assign mix_sum = acc_r + {prod_r[keb_pkg::HALF_W-1:0], {keb_pkg::HALF_W{1'b0}}};

  // Status
  assign status.word_ok   = (word_in >= keb_pkg::REJECT_LIMIT);
  assign status.edge_done = (lvl_inc >= {1'b0, lvl_eff});
  assign status.out_busy  = out_valid_r & ~out_ready;

  // Control state: prefixes, level count, output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_prefix_r <= '0;
      tgt_prefix_r <= '0;
      levels_r     <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cmd.level_step) begin
        if (status.edge_done) begin
          src_prefix_r <= '0;
          tgt_prefix_r <= '0;
          levels_r     <= '0;
        end else begin
          src_prefix_r <= src_next;
          tgt_prefix_r <= tgt_next;
          levels_r     <= lvl_inc[keb_pkg::LV_W-1:0];
        end
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.take_word) begin
      word_r  <= word_in;
      recip_r <= recip_prod;
    end
    if (cmd.qmul_load) begin
      qmul_r <= qmul_prod;
    end
    if (cmd.level_step && status.edge_done) begin
      edge_src_r <= src_next;
      edge_tgt_r <= tgt_next;
    end

    prod_r <= {{keb_pkg::HALF_W{1'b0}}, mul_a} * {{keb_pkg::HALF_W{1'b0}}, mul_b};

    unique case (cmd.acc_op)
      keb_pkg::ACC_LOAD: acc_r <= prod_r;
      keb_pkg::ACC_ADD:  acc_r <= mix_sum;
      default:           acc_r <= acc_r;
    endcase

    unique case (cmd.x_op)
      keb_pkg::X_ADD_SRC: x_r <= keb_pkg::KEY_W'(edge_src_r) + cfg.key_first + cfg.key_second;
      keb_pkg::X_ADD_TGT: x_r <= keb_pkg::KEY_W'(edge_tgt_r) + cfg.key_first + cfg.key_second;
      keb_pkg::X_MIX:     x_r <= rev64(mix_sum) >> shift_amt;
      default:            x_r <= x_r;
    endcase

    if (cmd.hold_src) begin
      res_src_r <= x_r[keb_pkg::OUT_W-1:0];
    end
    if (cmd.out_load) begin
      out_source_r <= res_src_r;
      out_target_r <= x_r[keb_pkg::OUT_W-1:0];
    end
  end

  assign out_valid  = out_valid_r;
  assign out_source = out_source_r;
  assign out_target = out_target_r;

endmodule

`default_nettype wire

/* hw/rtl/kronecker_edge_builder.sv */
// Top level of the Kronecker edge builder: configuration registers, controller, datapath.
// Depends on keb_pkg, keb_if, keb_cfg, keb_ctrl, keb_dp and the assertion macro header.
`default_nettype none

`include "kronecker_edge_builder_assert.svh"

// Builds one R-MAT edge from log_vertices kept random words (saturated to 1..48) and
// delivers it scrambled on out_edge. A word below 3647 is taken and dropped. A word
// that adds a level goes through take, quotient multiply and level update. The word
// that closes an edge then has both vertices go through one shared 32x32 multiplier,
// each needing an add step and two 64-bit multiplies of four steps, before the output
// register is loaded; that load waits while a previous edge is still held there. New
// words are taken while a finished edge waits on out_edge. Configuration writes take
// effect on the next cycle; the user must make them only while the block is idle,
// the block itself does not enforce this.
module kronecker_edge_builder (
  input  logic                               clk,
  input  logic                               rst_n,
  keb_word_if.sink                           in_word,
  keb_edge_if.source                         out_edge,
  input  logic                               cfg_we,
  input  logic [keb_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [keb_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  keb_pkg::cfg_t    cfg;
  keb_pkg::cmd_t    cmd;
  keb_pkg::status_t status;
  logic             in_ready;

  keb_cfg u_cfg (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (cfg_we),
    .index (cfg_index),
    .wdata (cfg_wdata),
    .cfg   (cfg)
  );

  keb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_word.valid),
    .status   (status),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  keb_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .cmd        (cmd),
    .word_in    (in_word.random_word),
    .out_ready  (out_edge.ready),
    .status     (status),
    .out_valid  (out_edge.valid),
    .out_source (out_edge.source_vertex),
    .out_target (out_edge.target_vertex)
  );

  assign in_word.ready = in_ready;

  // A kept word holds off the next transaction until its level is done
  `KEB_ASSERT_NEXT(a_word_blocks, clk, rst_n, in_word.valid && in_word.ready && (in_word.random_word >= keb_pkg::REJECT_LIMIT), !in_word.ready)
  // Reduction steps follow each other without a gap
  `KEB_ASSERT_NEXT(a_qmul_follows, clk, rst_n, cmd.take_word, cmd.qmul_load)
  // The output register is only overwritten once its edge has gone
  `KEB_ASSERT_SAME(a_out_free, clk, rst_n, cmd.out_load, !(out_edge.valid && !out_edge.ready))

endmodule

`default_nettype wire

/* tb/keb_edge_checker.sv */
// Edge checker for the Kronecker edge builder: follows the word and edge channels,
// predicts each scrambled edge and compares it with what the block delivers.
// Depends on keb_pkg for widths, register indexes and scramble constants.
module keb_edge_checker
  import keb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [WORD_W-1:0]     in_word,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [OUT_W-1:0]      out_source,
  input  logic [OUT_W-1:0]      out_target,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int unsigned           mismatches,
  output int unsigned           edges_due
);
  timeunit 1ns;
  timeprecision 1ps;

  // R-MAT quadrants: bit 1 goes to the source prefix, bit 0 to the target prefix
  typedef enum logic [1:0] {
    QUAD_A = 2'd0,
    QUAD_B = 2'd1,
    QUAD_C = 2'd2,
    QUAD_D = 2'd3
  } quad_e;

  typedef struct packed {
    logic [OUT_W-1:0] src;
    logic [OUT_W-1:0] tgt;
  } edge_pair_t;

  // Predicted edges, oldest first
  edge_pair_t edges_q[$];
  edge_pair_t seen_pair;
  edge_pair_t want_pair;

  // Register copies
  logic [LV_W-1:0]  log_vertices;
  logic [KEY_W-1:0] key_first;
  logic [KEY_W-1:0] key_second;
  logic [A_W-1:0]   a_share;
  logic [BC_W-1:0]  bc_share;

  // Edge under construction
  logic [PFX_W-1:0] src_prefix;
  logic [PFX_W-1:0] tgt_prefix;
  logic [LV_W-1:0]  level_count;

  function automatic logic [KEY_W-1:0] reverse_bits(input logic [KEY_W-1:0] x);
    logic [KEY_W-1:0] y;
    for (int i = 0; i < KEY_W; i++) y[i] = x[KEY_W-1-i];
    return y;
  endfunction

  // Hash a finished prefix into a vertex number of lg bits
  function automatic logic [KEY_W-1:0] scramble(input logic [KEY_W-1:0] pfx,
                                                input int unsigned lg);
    logic [KEY_W-1:0] v;
    int unsigned      sh;
    sh = KEY_W - lg;
    v = pfx + key_first + key_second;
    v = v * (key_first | MUL_FIRST);
    v = reverse_bits(v) >> sh;
    v = v * (key_second | MUL_SECOND);
    v = reverse_bits(v) >> sh;
    return v;
  endfunction

  // One accepted word: pick a quadrant, grow the prefixes, close the edge when due
  task automatic take_word(input logic [WORD_W-1:0] w);
    int unsigned      rem;
    int unsigned      lg;
    int unsigned      a_u;
    int unsigned      bc_u;
    logic [1:0]       quad;
    logic [KEY_W-1:0] src_v;
    logic [KEY_W-1:0] tgt_v;
    edge_pair_t       new_pair;
    if (w < REJECT_LIMIT) return;
    a_u  = a_share;
    bc_u = bc_share;
    lg   = log_vertices;
    if (lg < 1) lg = 1;
    if (lg > MAX_LOG_VERTICES) lg = MAX_LOG_VERTICES;
    rem = w % SHARE_DENOM;
    if (rem < bc_u) quad = QUAD_B;
    else if (rem < 2 * bc_u) quad = QUAD_C;
    else if (rem < 2 * bc_u + a_u) quad = QUAD_A;
    else quad = QUAD_D;
    // keep the graph undirected: no lower-triangle step while prefixes agree
    if (quad == QUAD_C && src_prefix == tgt_prefix) quad = QUAD_B;
    src_prefix  = {src_prefix[PFX_W-2:0], quad[1]};
    tgt_prefix  = {tgt_prefix[PFX_W-2:0], quad[0]};
    level_count = level_count + 1'b1;
    if (level_count >= lg) begin
      src_v = scramble(KEY_W'(src_prefix), lg);
      tgt_v = scramble(KEY_W'(tgt_prefix), lg);
      new_pair.src = src_v[OUT_W-1:0];
      new_pair.tgt = tgt_v[OUT_W-1:0];
      edges_q.insert(edges_q.size(), new_pair);
      src_prefix  = '0;
      tgt_prefix  = '0;
      level_count = '0;
    end
  endtask

  // Sample all channels at the clock edge
  always @(posedge clk) begin
    if (!rst_n) begin
      log_vertices = RST_LOG_VERTICES;
      key_first    = RST_KEY_FIRST;
      key_second   = RST_KEY_SECOND;
      a_share      = RST_A_SHARE;
      bc_share     = RST_BC_SHARE;
      src_prefix   = '0;
      tgt_prefix   = '0;
      level_count  = '0;
      mismatches   = 0;
      edges_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_LOG_VERTICES: log_vertices = cfg_wdata[LV_W-1:0];
          CFG_KEY_FIRST:    key_first    = cfg_wdata;
          CFG_KEY_SECOND:   key_second   = cfg_wdata;
          CFG_A_SHARE:      a_share      = cfg_wdata[A_W-1:0];
          CFG_BC_SHARE:     bc_share     = cfg_wdata[BC_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) take_word(in_word);
      if (out_valid && out_ready) begin
        seen_pair = '{src: out_source, tgt: out_target};
        if (edges_q.size() == 0) begin
          $display("%0t: edge with none predicted: source %h target %h",
                   $time, seen_pair.src, seen_pair.tgt);
          mismatches++;
        end else begin
          want_pair = edges_q.pop_front();
          if (seen_pair.src !== want_pair.src) begin
            $display("%0t: source_vertex expected %h got %h",
                     $time, want_pair.src, seen_pair.src);
            mismatches++;
          end
          if (seen_pair.tgt !== want_pair.tgt) begin
            $display("%0t: target_vertex expected %h got %h",
                     $time, want_pair.tgt, seen_pair.tgt);
            mismatches++;
          end
        end
      end
    end
    edges_due = edges_q.size();
  end

endmodule

/* tb/kronecker_edge_builder_test.sv */
// Top of the Kronecker edge builder testbench: clock, reset, register writes,
// word stimulus, edge back-pressure, watchdog and verdict.
// Depends on keb_pkg, keb_if, the RTL and keb_edge_checker.
module kronecker_edge_builder_test;
  timeunit 1ns;
  timeprecision 1ps;
  import keb_pkg::*;

  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned WATCH_LIMIT  = 4000;
  localparam int unsigned STALL_CYCLES = 300;
  localparam int unsigned PHASES       = 9;
  localparam int unsigned PHASE_WORDS  = 143;
  localparam int unsigned BURST_WORDS  = 40;
  localparam int unsigned MAX_K        = 214747;  // largest k with k*10000+9999 < 2^31

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int unsigned           mismatches;
  int unsigned           edges_due;
  int unsigned           send_idle_pct;
  int unsigned           recv_idle_pct;
  int unsigned           idle_cycles;
  logic                  stall_request;
  int unsigned           cur_a;
  int unsigned           cur_bc;

  keb_word_if word_ch();
  keb_edge_if edge_ch();

  kronecker_edge_builder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_word   (word_ch),
    .out_edge  (edge_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  keb_edge_checker edge_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (word_ch.valid),
    .in_ready   (word_ch.ready),
    .in_word    (word_ch.random_word),
    .out_valid  (edge_ch.valid),
    .out_ready  (edge_ch.ready),
    .out_source (edge_ch.source_vertex),
    .out_target (edge_ch.target_vertex),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .mismatches (mismatches),
    .edges_due  (edges_due)
  );

  // 10 ns clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Edge receiver: random back-pressure, plus one long hold-off on request
  initial begin
    edge_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst_n) begin
        edge_ch.ready <= 1'b0;
      end else if (stall_request) begin
        stall_request = 1'b0;
        edge_ch.ready <= 1'b0;
        repeat (STALL_CYCLES) @(posedge clk);
        edge_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end else begin
        edge_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if ((word_ch.valid && word_ch.ready) || (edge_ch.valid && edge_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCH_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  // Narrow registers get random upper bits, which the block must drop
  task automatic apply_settings(input logic [LV_W-1:0] lv, input logic [KEY_W-1:0] kf,
                                input logic [KEY_W-1:0] ks, input logic [A_W-1:0] a,
                                input logic [BC_W-1:0] bc);
    logic [CFG_DATA_W-1:0] junk;
    junk = {$urandom, $urandom};
    write_reg(CFG_LOG_VERTICES, {junk[CFG_DATA_W-1:LV_W], lv});
    write_reg(CFG_KEY_FIRST, kf);
    write_reg(CFG_KEY_SECOND, ks);
    write_reg(CFG_A_SHARE, {junk[CFG_DATA_W-1:A_W], a});
    write_reg(CFG_BC_SHARE, {junk[CFG_DATA_W-1:BC_W], bc});
    // an index past the register list must be ignored
    write_reg(CFG_BC_SHARE + CFG_IDX_W'(1 + $urandom_range(2)), junk);
    cfg_we <= 1'b0;
    cur_a  = a;
    cur_bc = bc;
  endtask

  task automatic send_word(input logic [WORD_W-1:0] w);
    if ($urandom_range(99) < send_idle_pct) begin
      word_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    word_ch.valid       <= 1'b1;
    word_ch.random_word <= w;
    do @(posedge clk); while (!word_ch.ready);
  endtask

  // Let every predicted edge arrive, then give the level pipeline time to settle
  task automatic wait_idle();
    @(posedge clk);
    while (edges_due != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Mostly full-range words, some near the reject limit, some on share boundaries
  function automatic logic [WORD_W-1:0] next_word();
    int unsigned pick;
    int unsigned t;
    pick = $urandom_range(99);
    if (pick < 80) return WORD_W'($urandom);
    if (pick < 88) return WORD_W'($urandom_range(REJECT_LIMIT + 200));
    case ($urandom_range(2))
      0:       t = cur_bc;
      1:       t = 2 * cur_bc;
      default: t = 2 * cur_bc + cur_a;
    endcase
    if (t > 0 && $urandom_range(1) == 1) t = t - 1;
    return WORD_W'($urandom_range(MAX_K, 1) * SHARE_DENOM + t % SHARE_DENOM);
  endfunction

  // Reset thresholds: b below 1900, c below 3800, a below 9500, d above
  logic [WORD_W-1:0] directed_words [22] = '{
    31'd0, 31'd3646, 31'd3647, 31'h7FFFFFFF, 31'd10000, 31'd19999,
    31'd11899, 31'd11900, 31'd13799, 31'd13800, 31'd19499, 31'd19500,
    31'h2AAAAAAA, 31'h55555555, 31'h7FFF0000, 31'h0000FFFF, 31'h40000000,
    31'd3648, 31'd13800, 31'd11900, 31'd1, 31'h7FFFFFFE
  };

  initial begin
    int unsigned      taken;
    rst_n               <= 1'b0;
    cfg_we              <= 1'b0;
    cfg_index           <= '0;
    cfg_wdata           <= '0;
    word_ch.valid       <= 1'b0;
    word_ch.random_word <= '0;
    idle_cycles         = 0;
    stall_request       = 1'b0;
    send_idle_pct       = 36;
    recv_idle_pct       = 69;
    cur_a               = RST_A_SHARE;
    cur_bc              = RST_BC_SHARE;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed words on the reset settings; leaves a part-built edge behind
    foreach (directed_words[i]) send_word(directed_words[i]);
    word_ch.valid <= 1'b0;
    wait_idle();

    // One level per edge with a long receiver hold-off: the block backs up
    apply_settings(6'd1, RST_KEY_FIRST, RST_KEY_SECOND, RST_A_SHARE, RST_BC_SHARE);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    stall_request = 1'b1;
    repeat (BURST_WORDS) send_word(next_word());
    word_ch.valid <= 1'b0;
    wait_idle();

    // Random phases, each on its own register settings
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: apply_settings(6'd1, '0, '0, '0, '0);
        1: apply_settings(6'd48, '1, '1, 14'd10000, 13'd5000);
        2: apply_settings(6'd0, {$urandom, $urandom}, {$urandom, $urandom}, '1, '1);
        3: apply_settings(6'd63, {$urandom, $urandom}, {$urandom, $urandom},
                          RST_A_SHARE, RST_BC_SHARE);
        4: apply_settings(6'd2, {$urandom, $urandom}, {$urandom, $urandom},
                          RST_A_SHARE, RST_BC_SHARE);
        5: apply_settings(LV_W'($urandom_range(8, 1)), {$urandom, $urandom},
                          {$urandom, $urandom}, A_W'($urandom_range(10000)),
                          BC_W'($urandom_range(5000)));
        6: apply_settings(6'd3, {$urandom, $urandom}, '0, '0, 13'd5000);
        7: apply_settings(LV_W'($urandom_range(10, 1)), {$urandom, $urandom},
                          {$urandom, $urandom}, A_W'($urandom), BC_W'($urandom));
        default: apply_settings(6'd5, '1, {$urandom, $urandom},
                                A_W'($urandom_range(10000)), BC_W'($urandom_range(5000)));
      endcase
      // idling: sender-light first, receiver-light next, none at the end
      if (ph < 3) begin
        send_idle_pct = 36;
        recv_idle_pct = 69;
      end else if (ph < 6) begin
        send_idle_pct = 69;
        recv_idle_pct = 36;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      // every word counts, kept or rejected
      taken = 0;
      while (taken < PHASE_WORDS) begin
        send_word(next_word());
        taken++;
      end
      word_ch.valid <= 1'b0;
      wait_idle();
    end

    if (mismatches == 0 && edges_due == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
